### rtl/core/cats_pkg.sv
// shared types, codes and checksum helper functions for the checksum engine
package cats_pkg;

   localparam int LenW  = 21;
   localparam int SumW  = 64;
   localparam int BeatW = 4;
   localparam int IdxW  = 2;

   localparam logic [2:0] AlgCrc32 = 3'd0;
   localparam logic [2:0] AlgCrc64 = 3'd1;
   localparam logic [2:0] AlgFnv32 = 3'd2;
   localparam logic [2:0] AlgFnv64 = 3'd3;
   localparam logic [2:0] AlgNone  = 3'd4;

   localparam logic OpAppend = 1'b0;
   localparam logic OpSearch = 1'b1;

   localparam logic [1:0] StatSumByte = 2'd0;
   localparam logic [1:0] StatSearch  = 2'd1;
   localparam logic [1:0] StatCapErr  = 2'd2;

   localparam logic [IdxW-1:0] RegAlgorithm = 2'd0;
   localparam logic [IdxW-1:0] RegOperation = 2'd1;
   localparam logic [IdxW-1:0] RegCapacity  = 2'd2;

   localparam logic [LenW-1:0] CapReset = 21'd1048584;

   localparam logic [SumW-1:0] PolyCrc32 = 64'h0000_0000_EDB8_8320;
   localparam logic [SumW-1:0] PolyCrc64 = 64'h95AC_9329_AC4B_C9B5;

   typedef struct packed {
      logic              load;
      logic [1:0]        status;
      logic [SumW-1:0]   sum;
      logic [LenW-1:0]   length;
      logic [BeatW-1:0]  beats;
   } cats_group_type;

   function automatic logic [SumW-1:0] init_value(input logic [2:0] alg);
      logic [SumW-1:0] v;
      case (alg)
         AlgCrc32: v = 64'h0000_0000_FFFF_FFFF;
         AlgCrc64: v = 64'hFFFF_FFFF_FFFF_FFFF;
         AlgFnv32: v = 64'h0000_0000_811C_9DC5;
         AlgFnv64: v = 64'hCBF2_9CE4_8422_2325;
         default:  v = '0;
      endcase
      return v;
   endfunction

   function automatic logic [SumW-1:0] crc_byte(input logic [SumW-1:0] s,
                                                input logic [7:0] b,
                                                input logic [SumW-1:0] poly);
      logic [SumW-1:0] v;
      v = s ^ {56'd0, b};
      for (int k = 0; k < 8; k++) begin
         v = v[0] ? ((v >> 1) ^ poly) : (v >> 1);
      end
      return v;
   endfunction

endpackage

### rtl/core/cats_if.sv
// handshake channels for input bytes, results and register writes
interface cats_req_if import cats_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;
   modport source(output valid, data_byte, last_byte, input ready);
   modport sink(input valid, data_byte, last_byte, output ready);
endinterface

interface cats_rsp_if import cats_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [1:0]      status;
   logic [7:0]      out_byte;
   logic [LenW-1:0] length;
   logic            last_out;
   modport source(output valid, status, out_byte, length, last_out, input ready);
   modport sink(input valid, status, out_byte, length, last_out, output ready);
endinterface

interface cats_csr_if import cats_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [IdxW-1:0] wr_index;
   logic [LenW-1:0] wr_data;
   modport source(output valid, wr_index, wr_data, input ready);
   modport sink(input valid, wr_index, wr_data, output ready);
endinterface

### rtl/core/cats_sum_update.sv
// one-byte update of the running crc or fnv-1a sum
module cats_sum_update import cats_pkg::*; (
   input  logic [2:0]      alg,
   input  logic [SumW-1:0] sum_cur,
   input  logic [7:0]      data_byte,
   output logic [SumW-1:0] sum_next
);

   logic [SumW-1:0] x64;
   logic [31:0]     x32;
   logic [SumW-1:0] fnv64;
   logic [31:0]     fnv32;

   // fnv primes split into a high power of two plus a small odd part
   assign x64   = sum_cur ^ {56'd0, data_byte};
   assign x32   = x64[31:0];
   assign fnv64 = (x64 << 40) + x64 + (x64 << 1) + (x64 << 4) + (x64 << 5)
                + (x64 << 7) + (x64 << 8);
   assign fnv32 = (x32 << 24) + x32 + (x32 << 1) + (x32 << 4) + (x32 << 7)
                + (x32 << 8);

   always_comb begin
      case (alg)
         AlgCrc32: sum_next = crc_byte({32'd0, sum_cur[31:0]}, data_byte, PolyCrc32);
         AlgCrc64: sum_next = crc_byte(sum_cur, data_byte, PolyCrc64);
         AlgFnv32: sum_next = {32'd0, fnv32};
         AlgFnv64: sum_next = fnv64;
         default:  sum_next = '0;
      endcase
   end

endmodule

### rtl/core/cats_result_out.sv
// result register that plays out a trailer group one beat per cycle while rsp_if.ready is high
module cats_result_out import cats_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  cats_group_type  group,
   output logic            free,
   cats_rsp_if.source      rsp_if
);

   logic             valid_ff,  valid_in;
   logic [1:0]       status_ff, status_in;
   logic [SumW-1:0]  sum_ff,    sum_in;
   logic [LenW-1:0]  length_ff, length_in;
   logic [BeatW-1:0] left_ff,   left_in;
   logic             final_beat;

   assign final_beat = (left_ff == BeatW'(1));
   assign free       = !valid_ff || (rsp_if.ready && final_beat);

   always_comb begin
      valid_in  = valid_ff;
      status_in = status_ff;
      sum_in    = sum_ff;
      length_in = length_ff;
      left_in   = left_ff;
      if (group.load) begin
         valid_in  = 1'b1;
         status_in = group.status;
         sum_in    = group.sum;
         length_in = group.length;
         left_in   = group.beats;
      end else if (valid_ff && rsp_if.ready) begin
         valid_in = !final_beat;
         sum_in   = sum_ff >> 8;
         left_in  = left_ff - BeatW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      sum_ff    <= sum_in;
      length_ff <= length_in;
      left_ff   <= left_in;
   end

   assign rsp_if.valid    = valid_ff;
   assign rsp_if.status   = status_ff;
   assign rsp_if.out_byte = sum_ff[7:0];
   assign rsp_if.length   = length_ff;
   assign rsp_if.last_out = final_beat;

endmodule

### rtl/core/checksum_append_and_trailer_search.sv
// top level: byte-stream checksum append and trailer search engine
// Takes one byte per cycle through an input register, where a last byte is held
// until the final beat of the previous trailer is taken, and updates the
// running CRC-32, CRC-64, FNV-1a-32 or FNV-1a-64 sum. In append mode the last
// byte yields a trailer of 4 or 8 checksum beats (least significant byte first,
// each carrying the total length) or one capacity error beat; in search mode it
// yields one beat with the first offset at which the preceding sum matches the
// next 4 or 8 bytes, 0 if none. Trailer beats leave the result register one per
// cycle while the receiver is ready, as later payload bytes keep flowing in.
// Writing algorithm or operation restarts the stream; capacity does not.
module checksum_append_and_trailer_search import cats_pkg::*; #(
   parameter int MAX_BYTES     = 1048576,
   parameter int MAX_SUM_BYTES = 8
) (
   input  logic       clock,
   input  logic       reset,
   cats_req_if.sink   req_if,
   cats_rsp_if.source rsp_if,
   cats_csr_if.sink   csr_if
);

   localparam int CntW  = $clog2(MAX_BYTES + 1);
   localparam int TotW  = (CntW + 1 > LenW) ? CntW + 1 : LenW;
   localparam int HistW = 8 * MAX_SUM_BYTES;
   localparam logic [BeatW-1:0] NarrowLen = BeatW'(4);
   localparam logic [BeatW-1:0] WideLen   = BeatW'(MAX_SUM_BYTES);
   localparam logic [CntW-1:0]  CntMax    = CntW'(MAX_BYTES);

   logic [2:0]       alg_ff;
   logic             op_ff;
   logic [LenW-1:0]  cap_ff;
   logic [SumW-1:0]  sum_ff;
   logic [CntW-1:0]  cnt_ff;
   logic             found_ff;
   logic [LenW-1:0]  offset_ff;
   logic [7:0]       win_ff  [MAX_SUM_BYTES];
   logic [HistW-1:0] hist_ff [MAX_SUM_BYTES];
   logic             in_valid_ff;
   logic [7:0]       in_byte_ff;
   logic             in_last_ff;

   logic             req_fire;
   logic             csr_fire;
   logic             out_free;
   logic             advance;
   logic             wide;
   logic [BeatW-1:0] sum_len;
   logic [SumW-1:0]  sum_next;
   logic [CntW-1:0]  cnt_in;
   logic [7:0]       win_new [MAX_SUM_BYTES];
   logic [31:0]      stored_narrow;
   logic [HistW-1:0] stored_wide;
   logic             cmp_hit;
   logic             hit;
   logic             found_in;
   logic [LenW-1:0]  offset_in;
   logic [TotW-1:0]  total;
   logic [TotW-1:0]  offset_calc;
   logic [TotW-1:0]  cap_ext;
   logic [2:0]       alg_new;
   cats_group_type   group;

   cats_sum_update u_sum (
      .alg       (alg_ff),
      .sum_cur   (sum_ff),
      .data_byte (in_byte_ff),
      .sum_next  (sum_next)
   );

   cats_result_out u_out (
      .clock  (clock),
      .reset  (reset),
      .group  (group),
      .free   (out_free),
      .rsp_if (rsp_if)
   );

   assign csr_if.ready = 1'b1;
   assign csr_fire     = csr_if.valid;
   assign advance      = in_valid_ff && (!in_last_ff || out_free);
   assign req_if.ready = !in_valid_ff || advance;
   assign req_fire     = req_if.valid && req_if.ready;

   assign wide    = (alg_ff == AlgCrc64) || (alg_ff == AlgFnv64);
   assign sum_len = wide ? WideLen : NarrowLen;
   assign cnt_in  = (cnt_ff == CntMax) ? cnt_ff : cnt_ff + CntW'(1);

   always_comb begin
      win_new[0] = in_byte_ff;
      for (int j = 1; j < MAX_SUM_BYTES; j++) begin
         win_new[j] = win_ff[j-1];
      end
      for (int m = 0; m < MAX_SUM_BYTES; m++) begin
         stored_wide[8*m +: 8] = win_new[MAX_SUM_BYTES-1-m];
      end
   end

   assign stored_narrow = {win_new[0], win_new[1], win_new[2], win_new[3]};

   // history entry L-1 after the shift is entry L-2 before it
   assign cmp_hit = wide ? (hist_ff[MAX_SUM_BYTES-2] == stored_wide)
                         : (hist_ff[2][31:0] == stored_narrow);
   assign hit     = (op_ff == OpSearch) && !found_ff
                 && (TotW'(cnt_in) >= TotW'(sum_len)) && cmp_hit;

   assign total       = TotW'(cnt_in) + TotW'(sum_len);
   assign offset_calc = TotW'(cnt_in) - TotW'(sum_len);
   assign cap_ext     = TotW'(cap_ff);
   assign found_in    = found_ff || hit;
   assign offset_in   = found_ff ? offset_ff : offset_calc[LenW-1:0];

   always_comb begin
      group        = '0;
      group.load   = advance && in_last_ff;
      group.beats  = BeatW'(1);
      if (op_ff == OpSearch) begin
         group.status = StatSearch;
         group.length = found_in ? offset_in : '0;
      end else if (cap_ext < total) begin
         group.status = StatCapErr;
      end else begin
         group.status = StatSumByte;
         group.sum    = sum_next;
         group.length = total[LenW-1:0];
         group.beats  = sum_len;
      end
   end

   assign alg_new = (csr_if.wr_index == RegAlgorithm) ? csr_if.wr_data[2:0] : alg_ff;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_fire) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_if.data_byte;
         in_last_ff <= req_if.last_byte;
      end
   end

   // configuration and stream state
   always_ff @(posedge clock) begin
      if (reset) begin
         alg_ff    <= AlgCrc32;
         op_ff     <= OpAppend;
         cap_ff    <= CapReset;
         sum_ff    <= init_value(AlgCrc32);
         cnt_ff    <= '0;
         found_ff  <= 1'b0;
         offset_ff <= '0;
      end else if (csr_fire) begin
         case (csr_if.wr_index)
            RegAlgorithm: begin
               alg_ff    <= csr_if.wr_data[2:0];
               sum_ff    <= init_value(alg_new);
               cnt_ff    <= '0;
               found_ff  <= 1'b0;
               offset_ff <= '0;
            end
            RegOperation: begin
               op_ff     <= csr_if.wr_data[0];
               sum_ff    <= init_value(alg_new);
               cnt_ff    <= '0;
               found_ff  <= 1'b0;
               offset_ff <= '0;
            end
            RegCapacity: begin
               cap_ff <= csr_if.wr_data;
            end
            default: begin
               cap_ff <= cap_ff;
            end
         endcase
      end else if (advance) begin
         if (in_last_ff) begin
            sum_ff    <= init_value(alg_ff);
            cnt_ff    <= '0;
            found_ff  <= 1'b0;
            offset_ff <= '0;
         end else begin
            sum_ff    <= sum_next;
            cnt_ff    <= cnt_in;
            found_ff  <= found_in;
            offset_ff <= offset_in;
         end
      end
   end

   // byte window and delay line of earlier sums
   always_ff @(posedge clock) begin
      if (advance) begin
         hist_ff[0] <= sum_ff[HistW-1:0];
         win_ff[0]  <= in_byte_ff;
         for (int k = 1; k < MAX_SUM_BYTES; k++) begin
            hist_ff[k] <= hist_ff[k-1];
            win_ff[k]  <= win_ff[k-1];
         end
      end
   end

endmodule

### tb/tb_checksum_append_and_trailer_search.sv
// self-checking testbench for the checksum append and trailer search engine
module tb_checksum_append_and_trailer_search;
   import cats_pkg::*;

   localparam int MaxBytes = 16;
   localparam int SettleCycles = 8;
   localparam int RandomBytes = 100;
   localparam logic [IdxW-1:0] RegUnused = 2'd3;
   localparam logic [LenW-1:0] LenAllOnes = 21'h1F_FFFF;

   typedef struct packed {
      logic [7:0] data;
      logic       is_last;
   } req_beat_type;

   typedef struct packed {
      logic [1:0]      status;
      logic [7:0]      out_byte;
      logic [LenW-1:0] length;
      logic            last_out;
   } rsp_beat_type;

   typedef logic [7:0] byte_seq_type[$];

   logic clock;
   logic reset;

   cats_req_if req_if();
   cats_rsp_if rsp_if();
   cats_csr_if csr_if();

   checksum_append_and_trailer_search #(
      .MAX_BYTES(MaxBytes),
      .MAX_SUM_BYTES(8)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_if(req_if),
      .rsp_if(rsp_if),
      .csr_if(csr_if)
   );

   // predicted engine state
   logic [2:0]      cfg_alg;
   logic            cfg_op;
   logic [LenW-1:0] cfg_cap;
   logic [63:0]     run_sum;
   int unsigned     byte_total;
   logic [7:0]      window[8];
   logic [63:0]     sum_delay[8];
   logic            found;
   logic [LenW-1:0] found_offset;

   req_beat_type pending_bytes[$];
   rsp_beat_type expected_beats[$];
   int unsigned  bytes_queued;
   int unsigned  bytes_accepted;
   int           fail_count;

   int burst_left;
   int gap_left;
   int stall_left;
   int stall_mode;
   int unsigned stall_tick;

   function automatic int sum_width(input logic [2:0] alg);
      return (alg == AlgCrc64 || alg == AlgFnv64) ? 8 : 4;
   endfunction

   function automatic logic [63:0] seed_of(input logic [2:0] alg);
      logic [63:0] v;
      case (alg)
         AlgCrc32: v = 64'h0000_0000_FFFF_FFFF;
         AlgCrc64: v = 64'hFFFF_FFFF_FFFF_FFFF;
         AlgFnv32: v = 64'h0000_0000_811C_9DC5;
         AlgFnv64: v = 64'hCBF2_9CE4_8422_2325;
         default:  v = '0;
      endcase
      return v;
   endfunction

   function automatic logic [63:0] advance_sum(input logic [2:0] alg, input logic [63:0] s,
                                                input logic [7:0] b);
      logic [63:0] v;
      logic [63:0] poly;
      logic [31:0] h;
      v = '0;
      case (alg)
         AlgCrc32, AlgCrc64: begin
            poly = (alg == AlgCrc32) ? PolyCrc32 : PolyCrc64;
            v = (alg == AlgCrc32) ? {32'd0, s[31:0]} : s;
            v = v ^ {56'd0, b};
            for (int k = 0; k < 8; k++) begin
               v = v[0] ? ((v >> 1) ^ poly) : (v >> 1);
            end
         end
         AlgFnv32: begin
            h = s[31:0] ^ {24'd0, b};
            h = h * 32'd16777619;
            v = {32'd0, h};
         end
         AlgFnv64: v = (s ^ {56'd0, b}) * 64'd1099511628211;
         default: v = '0;
      endcase
      return v;
   endfunction

   task automatic restart_stream();
      run_sum = seed_of(cfg_alg);
      byte_total = 0;
      for (int k = 0; k < 8; k++) window[k] = '0;
      found = 1'b0;
      found_offset = '0;
   endtask

   task automatic apply_config(input logic [IdxW-1:0] idx, input logic [LenW-1:0] data);
      case (idx)
         RegAlgorithm: begin
            cfg_alg = data[2:0];
            restart_stream();
         end
         RegOperation: begin
            cfg_op = data[0];
            restart_stream();
         end
         RegCapacity: cfg_cap = data;
         default: ;
      endcase
   endtask

   task automatic predict_byte(input logic [7:0] b, input logic is_last);
      int           width;
      logic [63:0]  mask;
      logic [63:0]  stored;
      logic [31:0]  total;
      rsp_beat_type beat;
      width = sum_width(cfg_alg);
      mask = (width >= 8) ? '1 : ((64'd1 << (8 * width)) - 64'd1);
      for (int k = 7; k > 0; k--) begin
         sum_delay[k] = sum_delay[k-1];
         window[k] = window[k-1];
      end
      sum_delay[0] = run_sum;
      window[0] = b;
      run_sum = advance_sum(cfg_alg, run_sum, b);
      if (byte_total < MaxBytes) byte_total++;
      if (cfg_op == OpSearch && !found && byte_total >= width) begin
         stored = '0;
         for (int m = 0; m < width; m++) stored[8*m +: 8] = window[width-1-m];
         if ((sum_delay[width-1] & mask) == stored) begin
            found = 1'b1;
            found_offset = LenW'(byte_total - width);
         end
      end
      if (is_last) begin
         beat.out_byte = '0;
         beat.length = '0;
         beat.last_out = 1'b1;
         if (cfg_op == OpSearch) begin
            beat.status = StatSearch;
            beat.length = found ? found_offset : '0;
            expected_beats.push_back(beat);
         end else begin
            total = byte_total + width;
            if (cfg_cap < total) begin
               beat.status = StatCapErr;
               expected_beats.push_back(beat);
            end else begin
               for (int m = 0; m < width; m++) begin
                  beat.status = StatSumByte;
                  beat.out_byte = run_sum[8*m +: 8];
                  beat.length = total[LenW-1:0];
                  beat.last_out = (m == width - 1);
                  expected_beats.push_back(beat);
               end
            end
         end
         restart_stream();
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5000000;
      $display("checksum_append_and_trailer_search regression: fail");
      $finish;
   end

   // input driver: bursts of beats with random gaps
   always @(posedge clock) begin : req_drive
      req_beat_type item;
      if (reset) begin
         req_if.valid <= 1'b0;
         burst_left <= 0;
         gap_left <= 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            predict_byte(req_if.data_byte, req_if.last_byte);
            bytes_accepted++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_if.valid <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
               item = pending_bytes.pop_front();
               req_if.valid <= 1'b1;
               req_if.data_byte <= item.data;
               req_if.last_byte <= item.is_last;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 24);
                  gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // result backpressure in phases of varying stall density
   always @(posedge clock) begin
      stall_tick <= stall_tick + 1;
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(8, 40);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: rsp_if.ready <= 1'b1;
         1: rsp_if.ready <= ($urandom_range(0, 1) == 1);
         2: rsp_if.ready <= ($urandom_range(0, 3) == 0);
         default: rsp_if.ready <= stall_tick[1];
      endcase
   end

   always @(posedge clock) begin : rsp_check
      rsp_beat_type exp_beat;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_beats.size() == 0) begin
            $error("unexpected result beat: status %0d out_byte %0h length %0d last_out %0b",
                   rsp_if.status, rsp_if.out_byte, rsp_if.length, rsp_if.last_out);
            fail_count++;
         end else begin
            exp_beat = expected_beats.pop_front();
            if (rsp_if.status !== exp_beat.status) begin
               $error("status: expected %0d, got %0d", exp_beat.status, rsp_if.status);
               fail_count++;
            end
            if (rsp_if.out_byte !== exp_beat.out_byte) begin
               $error("out_byte: expected %0h, got %0h", exp_beat.out_byte, rsp_if.out_byte);
               fail_count++;
            end
            if (rsp_if.length !== exp_beat.length) begin
               $error("length: expected %0d, got %0d", exp_beat.length, rsp_if.length);
               fail_count++;
            end
            if (rsp_if.last_out !== exp_beat.last_out) begin
               $error("last_out: expected %0b, got %0b", exp_beat.last_out, rsp_if.last_out);
               fail_count++;
            end
         end
      end
   end

   task automatic queue_stream(input byte_seq_type seq, input bit terminate);
      req_beat_type item;
      for (int i = 0; i < seq.size(); i++) begin
         item.data = seq[i];
         item.is_last = terminate && (i == seq.size() - 1);
         pending_bytes.push_back(item);
         bytes_queued++;
      end
   endtask

   function automatic byte_seq_type random_bytes(input int n);
      byte_seq_type seq;
      for (int i = 0; i < n; i++) seq.push_back(8'($urandom_range(0, 255)));
      return seq;
   endfunction

   // prefix, then its sum little-endian, then trailing bytes
   task automatic queue_trailer_stream(input byte_seq_type prefix, input int post_len,
                                       input bit corrupt);
      byte_seq_type seq;
      byte_seq_type tail;
      logic [63:0]  s;
      int           width;
      int           pos;
      width = sum_width(cfg_alg);
      s = seed_of(cfg_alg);
      seq = prefix;
      for (int i = 0; i < prefix.size(); i++) s = advance_sum(cfg_alg, s, prefix[i]);
      for (int m = 0; m < width; m++) seq.push_back(s[8*m +: 8]);
      if (corrupt) begin
         pos = prefix.size() + $urandom_range(0, width - 1);
         seq[pos] = seq[pos] ^ (8'h01 << $urandom_range(0, 7));
      end
      tail = random_bytes(post_len);
      for (int i = 0; i < tail.size(); i++) seq.push_back(tail[i]);
      queue_stream(seq, 1'b1);
   endtask

   task automatic wait_idle();
      while (!(bytes_accepted == bytes_queued && expected_beats.size() == 0))
         @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_reg(input logic [IdxW-1:0] idx, input logic [LenW-1:0] data);
      @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.wr_index <= idx;
      csr_if.wr_data <= data;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      apply_config(idx, data);
      csr_if.valid <= 1'b0;
   endtask

   initial begin : stimulus
      byte_seq_type    seq;
      logic [LenW-1:0] wr;
      int unsigned     random_start;
      int              streams;
      int              len;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.data_byte = '0;
      req_if.last_byte = 1'b0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.wr_index = '0;
      csr_if.wr_data = '0;
      bytes_queued = 0;
      bytes_accepted = 0;
      fail_count = 0;
      stall_left = 0;
      stall_mode = 0;
      stall_tick = 0;
      cfg_alg = AlgCrc32;
      cfg_op = OpAppend;
      cfg_cap = CapReset;
      for (int k = 0; k < 8; k++) sum_delay[k] = '0;
      restart_stream();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset defaults: crc-32 append
      seq = '{8'h00, 8'hFF};
      queue_stream(seq, 1'b1);
      wait_idle();

      // algorithm write in the middle of a stream restarts it
      seq = '{8'h5A, 8'hA5};
      queue_stream(seq, 1'b0);
      wait_idle();
      write_reg(RegAlgorithm, LenW'(AlgCrc64));
      seq = '{8'h80};
      queue_stream(seq, 1'b1);
      wait_idle();

      // capacity error, then an exact fit
      write_reg(RegCapacity, '0);
      seq = '{8'hFF};
      queue_stream(seq, 1'b1);
      wait_idle();
      write_reg(RegCapacity, 21'd9);
      seq = '{8'h01};
      queue_stream(seq, 1'b1);
      wait_idle();

      write_reg(RegCapacity, CapReset);
      write_reg(RegAlgorithm, LenW'(AlgFnv32));
      seq = '{8'h61};
      queue_stream(seq, 1'b1);
      wait_idle();
      write_reg(RegAlgorithm, LenW'(AlgFnv64));
      seq = '{8'h61};
      queue_stream(seq, 1'b1);
      wait_idle();
      // unused code behaves as no checksum
      write_reg(RegAlgorithm, 21'd7);
      seq = '{8'h7E};
      queue_stream(seq, 1'b1);
      wait_idle();
      write_reg(RegUnused, LenAllOnes);

      // search: match at offset zero wins over a later valid trailer
      write_reg(RegOperation, LenW'(OpSearch));
      write_reg(RegAlgorithm, LenW'(AlgCrc32));
      seq = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
      queue_trailer_stream(seq, 0, 1'b0);
      queue_trailer_stream(random_bytes(1), 0, 1'b0);
      wait_idle();

      random_start = bytes_queued;
      streams = 0;
      while (bytes_queued - random_start < RandomBytes || streams < 10) begin
         if ($urandom_range(0, 2) == 0) begin
            wait_idle();
            if ($urandom_range(0, 1) == 1) begin
               wr = LenW'($urandom_range(0, LenAllOnes));
               wr[2:0] = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(5, 7))
                                                      : 3'($urandom_range(0, 4));
               write_reg(RegAlgorithm, wr);
            end
            if ($urandom_range(0, 1) == 1) begin
               wr = LenW'($urandom_range(0, LenAllOnes));
               write_reg(RegOperation, wr);
            end
            if ($urandom_range(0, 1) == 1) begin
               case ($urandom_range(0, 4))
                  0: wr = '0;
                  1: wr = LenW'($urandom_range(0, 30));
                  2: wr = CapReset;
                  3: wr = LenAllOnes;
                  default: wr = LenW'($urandom_range(0, LenAllOnes));
               endcase
               write_reg(RegCapacity, wr);
            end
         end
         // long streams drive the byte count into saturation
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 22) : $urandom_range(1, 12);
         if (cfg_op == OpSearch && $urandom_range(0, 9) < 7) begin
            queue_trailer_stream(random_bytes($urandom_range(0, 6)), $urandom_range(0, 3),
                                 $urandom_range(0, 4) == 0);
         end else begin
            queue_stream(random_bytes(len), 1'b1);
         end
         streams++;
      end

      wait_idle();
      if (fail_count == 0) begin
         $display("checksum_append_and_trailer_search regression: pass");
      end else begin
         $display("checksum_append_and_trailer_search regression: fail");
      end
      $finish;
   end

endmodule
